// ===== design/sorted_key_index_table_defines.svh =====
`ifndef SORTED_KEY_INDEX_TABLE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_DEFINES_SVH
// assertion helpers
`define SKIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SKIT_ASSERT_NORST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== design/skit_pkg.sv =====
package skit_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int KEY_BYTES = 22;
	localparam int RECORD_BITS = 10;
	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = KEY_W + RECORD_BITS;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_RENAME = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NO_REM = 2'd3;

	localparam logic [7:0] BANG = 8'h21;

	typedef logic [KEY_W-1:0] key_t;

	// three-way compare: 2'b00 equal, 2'b10 a<b, 2'b01 a>b
	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_t;

	function automatic cmp_t key_cmp(key_t a, key_t b);
		cmp_t r;
		logic done;
		logic [7:0] x;
		logic [7:0] y;
		r = '0;
		done = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			x = a[KEY_W-1-8*i -: 8];
			y = b[KEY_W-1-8*i -: 8];
			if (!done) begin
				if (x != y) begin
					r.lt = (x < y);
					r.gt = (x > y);
					done = 1'b1;
				end else if (x == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction
endpackage

// ===== design/skit_ram.sv =====
module skit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/sorted_key_index_table.sv =====
// Sorted key index table, one request at a time. A request is taken at a clock edge with start
// high and busy low. Busy then stays high until the single-cycle done strobe, which carries
// status, found_position, found_record and entries_held. The strobe cannot be held off, so
// capture the result in that cycle. All entries sit in one slot memory (key plus record number)
// with a registered read. Lookup probes the low end, the high end and the middle of a shrinking
// window, each probe a read state then a compare state. That is up to 8 probes at a full table.
// Insert starts at the end and shifts each larger key up one slot, then writes the new entry into
// the gap. Delete and rename first read the remembered slot, then move its new key up or down in
// the same way. After done the block returns to idle before it takes the next request. There is
// no clearing pass after reset, since only entries below the count are read.
module sorted_key_index_table
	import skit_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             mode,
	input  logic [47:0]            key_high,
	input  logic [63:0]            key_mid,
	input  logic [63:0]            key_low,
	input  logic [9:0]             record_number,
	output logic                   done,
	output logic [1:0]             status,
	output logic [3:0]             found_position,
	output logic [9:0]             found_record,
	output logic [4:0]             entries_held
);
	`include "sorted_key_index_table_defines.svh"

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LK_RD = 4'd1;
	localparam logic [3:0] S_LK_CMP = 4'd2;
	localparam logic [3:0] S_UP_RD = 4'd3;
	localparam logic [3:0] S_UP_CMP = 4'd4;
	localparam logic [3:0] S_DN_RD = 4'd5;
	localparam logic [3:0] S_DN_CMP = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;
	localparam logic [3:0] S_RC_RD = 4'd8;
	localparam logic [3:0] S_RC_CAP = 4'd9;
	localparam logic [3:0] S_WR = 4'd10;

	localparam logic [1:0] PR_LO = 2'd0;
	localparam logic [1:0] PR_HI = 2'd1;
	localparam logic [1:0] PR_MID = 2'd2;

	logic [3:0] state_q;
	logic [1:0] probe_q;
	logic [1:0] mode_q;
	key_t key_q;
	logic [RECORD_BITS-1:0] rec_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] rem_pos_q;
	logic rem_valid_q;
	logic [IDX_W-1:0] lo_q, hi_q, cur_q;
	logic [1:0] status_q;
	logic [IDX_W-1:0] pos_q;
	logic [RECORD_BITS-1:0] frec_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [SLOT_W-1:0] wdata, rdata;

	skit_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_slots (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	key_t in_key;
	key_t rd_key;
	logic [RECORD_BITS-1:0] rd_rec;
	cmp_t c;
	logic [IDX_W:0] mid_sum;
	logic [IDX_W-1:0] mid;
	logic moved;

	function automatic logic [IDX_W-1:0] raddr_hold(logic [1:0] p, logic [IDX_W-1:0] l,
			logic [IDX_W-1:0] h, logic [IDX_W-1:0] m);
		case (p)
			PR_LO: return l;
			PR_HI: return h;
			default: return m;
		endcase
	endfunction

	always_comb begin
		in_key = {key_high, key_mid, key_low};
		rd_key = rdata[SLOT_W-1 -: KEY_W];
		rd_rec = rdata[RECORD_BITS-1:0];
		c = key_cmp(rd_key, key_q);
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid = mid_sum[IDX_W:1];
		moved = (mode_q == MODE_INSERT) || (cur_q != pos_q);
	end

	// lookup probe address and sorting read address
	always_comb begin
		raddr = cur_q;
		if (state_q == S_LK_RD) begin
			case (probe_q)
				PR_LO: raddr = lo_q;
				PR_HI: raddr = hi_q;
				default: raddr = mid;
			endcase
		end else if (state_q == S_UP_RD) begin
			raddr = cur_q - 1'b1;
		end else if (state_q == S_DN_RD) begin
			raddr = cur_q + 1'b1;
		end
	end

	// moving slot: key_q/rec_q, at cur_q; neighbor read in rdata
	always_comb begin
		we = 1'b0;
		waddr = cur_q;
		wdata = {key_q, rec_q};
		if (state_q == S_UP_CMP && c.gt) begin
			we = 1'b1;
			wdata = rdata;
		end else if (state_q == S_UP_CMP && moved) begin
			we = 1'b1;
		end else if (state_q == S_DN_CMP && c.lt) begin
			we = 1'b1;
			wdata = rdata;
		end else if ((state_q == S_DN_CMP) || (state_q == S_WR)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_pos_q <= '0;
			rem_valid_q <= 1'b0;
			probe_q <= PR_LO;
			mode_q <= MODE_INSERT;
			key_q <= '0;
			rec_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			cur_q <= '0;
			status_q <= ST_OK;
			pos_q <= '0;
			frec_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						key_q <= in_key;
						rec_q <= record_number[RECORD_BITS-1:0];
						status_q <= ST_OK;
						pos_q <= '0;
						frec_q <= '0;
						state_q <= S_DONE;
						case (mode)
							MODE_INSERT: begin
								if (count_q >= CNT_W'(TABLE_DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									cur_q <= count_q[IDX_W-1:0];
									count_q <= count_q + 1'b1;
									pos_q <= count_q[IDX_W-1:0];
									state_q <= S_UP_RD;
								end
							end
							MODE_LOOKUP: begin
								if (count_q == '0) begin
									status_q <= ST_NOT_FOUND;
								end else begin
									lo_q <= '0;
									hi_q <= IDX_W'(count_q - 1'b1);
									probe_q <= PR_LO;
									state_q <= S_LK_RD;
								end
							end
							default: begin
								if (!rem_valid_q || {1'b0, rem_pos_q} >= count_q) begin
									status_q <= ST_NO_REM;
								end else begin
									pos_q <= rem_pos_q;
									cur_q <= rem_pos_q;
									if (mode == MODE_DELETE) begin
										key_q <= {BANG, {(KEY_W-8){1'b0}}};
									end
									state_q <= S_RC_RD;
								end
							end
						endcase
					end
				end
				S_LK_RD: state_q <= S_LK_CMP;
				S_LK_CMP: begin
					state_q <= S_LK_RD;
					if (!c.lt && !c.gt) begin
						pos_q <= raddr_hold(probe_q, lo_q, hi_q, mid);
						rem_pos_q <= raddr_hold(probe_q, lo_q, hi_q, mid);
						rem_valid_q <= 1'b1;
						frec_q <= rd_rec;
						state_q <= S_DONE;
					end else begin
						case (probe_q)
							PR_LO: probe_q <= PR_HI;
							PR_HI: begin
								if (mid == lo_q || mid == hi_q) begin
									status_q <= ST_NOT_FOUND;
									state_q <= S_DONE;
								end else begin
									probe_q <= PR_MID;
								end
							end
							default: begin
								probe_q <= PR_LO;
								if (c.gt) begin
									lo_q <= lo_q + 1'b1;
									hi_q <= mid - 1'b1;
								end else begin
									lo_q <= mid + 1'b1;
									hi_q <= hi_q - 1'b1;
								end
							end
						endcase
					end
				end
				S_RC_RD: state_q <= S_RC_CAP;
				S_RC_CAP: begin
					rec_q <= rd_rec;
					state_q <= S_UP_RD;
				end
				S_UP_RD: begin
					if (cur_q != '0) begin
						state_q <= S_UP_CMP;
					end else if (moved) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_DN_RD;
					end
				end
				S_UP_CMP: begin
					if (c.gt) begin
						cur_q <= cur_q - 1'b1;
						if (mode_q == MODE_INSERT) begin
							pos_q <= cur_q - 1'b1;
						end
						state_q <= S_UP_RD;
					end else if (moved) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: begin
					if ({1'b0, cur_q} + 1'b1 >= count_q) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (c.lt) begin
						cur_q <= cur_q + 1'b1;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WR: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = status_q;
	assign found_position = (status_q == ST_OK) ? 4'(pos_q) : 4'd0;
	assign found_record = (status_q == ST_OK && mode_q == MODE_LOOKUP) ? 10'(frec_q) : 10'd0;
	assign entries_held = 5'(count_q);

	`SKIT_ASSERT(a_done_pulse, done |=> !done, "done longer than one cycle")
	`SKIT_ASSERT(a_count_max, count_q <= CNT_W'(TABLE_DEPTH), "count above depth")
	`SKIT_ASSERT(a_start_busy, (start && !busy) |=> busy, "request not taken")
	`SKIT_ASSERT_NORST(a_rst_idle, !arst_n |-> !busy, "busy during reset")
endmodule

// ===== tb/sorted_key_index_table_test.sv =====
module sorted_key_index_table_test;
	timeunit 1ns;
	timeprecision 1ps;
	import skit_pkg::*;

	typedef struct {
		logic [1:0] op;
		key_t       key;
		logic [9:0] rec;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [3:0] position;
		logic [9:0] record;
		logic [4:0] held;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_INSERT;
	logic [47:0] key_high = '0;
	logic [63:0] key_mid = '0;
	logic [63:0] key_low = '0;
	logic [9:0]  record_number = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [3:0]  found_position;
	logic [9:0]  found_record;
	logic [4:0]  entries_held;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	key_t     known_keys[$];
	int       gap = 0;
	bit       failed = 1'b0;

	key_t       table_key[TABLE_DEPTH];
	logic [9:0] table_rec[TABLE_DEPTH];
	int         table_count = 0;
	int         marked_pos = 0;
	bit         marked_ok = 1'b0;

	sorted_key_index_table uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int order_keys(key_t a, key_t b);
		logic [7:0] x;
		logic [7:0] y;
		for (int i = 0; i < KEY_BYTES; i++) begin
			x = a[KEY_W-1-8*i -: 8];
			y = b[KEY_W-1-8*i -: 8];
			if (x != y)
				return (x < y) ? -1 : 1;
			if (x == 8'd0)
				return 0;
		end
		return 0;
	endfunction

	function automatic void resort_table();
		key_t       k;
		logic [9:0] r;
		int         j;
		for (int i = 1; i < table_count; i++) begin
			k = table_key[i];
			r = table_rec[i];
			j = i;
			while (j > 0 && order_keys(table_key[j-1], k) > 0) begin
				table_key[j] = table_key[j-1];
				table_rec[j] = table_rec[j-1];
				j--;
			end
			table_key[j] = k;
			table_rec[j] = r;
		end
	endfunction

	function automatic bit probe_table(key_t k, output int pos);
		int lo;
		int hi;
		int mid;
		int c;
		pos = 0;
		if (table_count == 0)
			return 1'b0;
		lo = 0;
		hi = table_count - 1;
		for (int g = 0; g <= TABLE_DEPTH; g++) begin
			mid = (lo + hi) / 2;
			if (order_keys(table_key[lo], k) == 0) begin
				pos = lo;
				return 1'b1;
			end
			if (order_keys(table_key[hi], k) == 0) begin
				pos = hi;
				return 1'b1;
			end
			if (mid == lo || mid == hi)
				return 1'b0;
			c = order_keys(table_key[mid], k);
			if (c == 0) begin
				pos = mid;
				return 1'b1;
			end
			if (c > 0) begin
				lo = lo + 1;
				hi = mid - 1;
			end else begin
				lo = mid + 1;
				hi = hi - 1;
			end
		end
		return 1'b0;
	endfunction

	function automatic answer_t apply_request(request_t q);
		answer_t a;
		int      p;
		a = '{ST_OK, 4'd0, 10'd0, 5'd0};
		case (q.op)
			MODE_INSERT: begin
				if (table_count >= TABLE_DEPTH) begin
					a.status = ST_FULL;
				end else begin
					p = 0;
					for (int i = 0; i < table_count; i++)
						if (order_keys(table_key[i], q.key) <= 0)
							p++;
					a.position = 4'(p);
					table_key[table_count] = q.key;
					table_rec[table_count] = q.rec;
					table_count++;
					resort_table();
				end
			end
			MODE_LOOKUP: begin
				if (probe_table(q.key, p)) begin
					a.position = 4'(p);
					a.record = table_rec[p];
					marked_pos = p;
					marked_ok = 1'b1;
				end else begin
					a.status = ST_NOT_FOUND;
				end
			end
			default: begin
				if (!marked_ok || marked_pos >= table_count) begin
					a.status = ST_NO_REM;
				end else begin
					a.position = 4'(marked_pos);
					table_key[marked_pos] = (q.op == MODE_DELETE) ?
						{BANG, {(KEY_W-8){1'b0}}} : q.key;
					resort_table();
				end
			end
		endcase
		a.held = 5'(table_count);
		return a;
	endfunction

	function automatic key_t random_bits();
		return KEY_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom()});
	endfunction

	// fill bytes past the first zero with noise; the key still compares the same
	function automatic key_t garble_tail(key_t k);
		key_t n;
		bit   hit;
		n = random_bits();
		hit = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (hit)
				k[KEY_W-1-8*i -: 8] = n[KEY_W-1-8*i -: 8];
			else if (k[KEY_W-1-8*i -: 8] == 8'd0)
				hit = 1'b1;
		end
		return k;
	endfunction

	function automatic key_t short_key();
		key_t k;
		int   len;
		k = '0;
		len = $urandom_range(1, KEY_BYTES);
		for (int i = 0; i < len; i++)
			k[KEY_W-1-8*i -: 8] = 8'h41 + 8'($urandom_range(0, 3));
		return garble_tail(k);
	endfunction

	function automatic key_t pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6 && known_keys.size() > 0)
			return garble_tail(known_keys[$urandom_range(0, known_keys.size() - 1)]);
		if (sel < 8)
			return short_key();
		if (sel == 8)
			return garble_tail({BANG, {(KEY_W-8){1'b0}}});
		return random_bits();
	endfunction

	function automatic void add_request(logic [1:0] op, key_t k, logic [9:0] r);
		request_t q;
		q.op = op;
		q.key = k;
		q.rec = r;
		pending_requests.push_back(q);
		if (op == MODE_INSERT || op == MODE_RENAME)
			known_keys.push_back(k);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		request_t q;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				expected_answers.push_back(apply_request('{mode, {key_high, key_mid, key_low},
					record_number}));
			if (!start || !busy) begin
				if (gap > 0) begin
					gap <= gap - 1;
					start <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					q = pending_requests.pop_front();
					mode <= q.op;
					{key_high, key_mid, key_low} <= q.key;
					record_number <= q.rec;
					start <= 1'b1;
					gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("result with no request pending");
				failed = 1'b1;
			end else begin
				e = expected_answers.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					failed = 1'b1;
				end
				if (found_position !== e.position) begin
					$error("found_position expected %0d actual %0d", e.position, found_position);
					failed = 1'b1;
				end
				if (found_record !== e.record) begin
					$error("found_record expected %0d actual %0d", e.record, found_record);
					failed = 1'b1;
				end
				if (entries_held !== e.held) begin
					$error("entries_held expected %0d actual %0d", e.held, entries_held);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		key_t bang;
		key_t k;
		int   r;
		#1 arst_n = 1'b0;
		bang = {BANG, {(KEY_W-8){1'b0}}};
		add_request(MODE_LOOKUP, short_key(), 10'd5);
		add_request(MODE_DELETE, short_key(), 10'd0);
		add_request(MODE_RENAME, short_key(), 10'd0);
		add_request(MODE_INSERT, {"BETA", {(KEY_W-32){1'b0}}}, 10'd1023);
		add_request(MODE_INSERT, '0, 10'd0);
		add_request(MODE_INSERT, '1, 10'd512);
		add_request(MODE_INSERT, {"BETA", 8'h00, {(KEY_W-40){1'b1}}}, 10'd7);
		add_request(MODE_INSERT, bang, 10'd9);
		add_request(MODE_INSERT, {"ALPHA", {(KEY_W-40){1'b0}}}, 10'd33);
		add_request(MODE_LOOKUP, {"GAMMA", {(KEY_W-40){1'b0}}}, 10'd0);
		add_request(MODE_LOOKUP, {"BETA", 8'h00, 136'h5a}, 10'd0);
		add_request(MODE_DELETE, '0, 10'd0);
		add_request(MODE_LOOKUP, bang, 10'd0);
		add_request(MODE_LOOKUP, '1, 10'd0);
		add_request(MODE_RENAME, {"ZETA", {(KEY_W-32){1'b0}}}, 10'd0);
		add_request(MODE_LOOKUP, '0, 10'd0);
		add_request(MODE_RENAME, random_bits(), 10'd0);
		repeat (650) begin
			r = $urandom_range(0, 99);
			k = pick_key();
			if (r < 15)
				add_request(MODE_INSERT, k, 10'($urandom_range(0, 1023)));
			else if (r < 65)
				add_request(MODE_LOOKUP, k, 10'($urandom_range(0, 1023)));
			else if (r < 80)
				add_request(MODE_DELETE, k, 10'($urandom_range(0, 1023)));
			else
				add_request(MODE_RENAME, k, 10'($urandom_range(0, 1023)));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0 && !start && expected_answers.size() == 0);
		repeat (60) @(posedge clk);
		if (!failed && expected_answers.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end
endmodule

// ===== sorted_key_index_table.f =====
+incdir+design
design/skit_pkg.sv
design/skit_ram.sv
design/sorted_key_index_table.sv
tb/sorted_key_index_table_test.sv
